/* hdl/pbd_pkg.sv */
// Package for the PPG beat detector: widths, template coefficients, register indexes.
// No dependencies.
package pbd_pkg;

    localparam int TapsDefault    = 49;
    localparam int MeanLenDefault = 5;
    localparam int TplLen         = 49;

    localparam logic [1:0] RegHpfShift  = 2'd0;
    localparam logic [1:0] RegMinPeriod = 2'd1;
    localparam logic [1:0] RegMaxPeriod = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FINISH,
        ST_OUT
    } pbd_state_t;

    // Control from the sequencer to the cell row
    typedef struct packed {
        logic load;
        logic rotate;
        logic push;
    } pbd_row_ctl_t;

    function automatic logic signed [15:0] tpl_coef(input int n);
        logic signed [15:0] c;
        begin
            c = 16'sd0;
            unique case (n)
                0: c = 16'sd129;     1: c = -16'sd385;    2: c = -16'sd1814;
                3: c = -16'sd3948;   4: c = -16'sd6602;   5: c = -16'sd9608;
                6: c = -16'sd12820;  7: c = -16'sd16105;  8: c = -16'sd19345;
                9: c = -16'sd22435;  10: c = -16'sd25275; 11: c = -16'sd27775;
                12: c = -16'sd29851; 13: c = -16'sd31419; 14: c = -16'sd32402;
                15: c = -16'sd32726; 16: c = -16'sd32323; 17: c = -16'sd31129;
                18: c = -16'sd29097; 19: c = -16'sd26192; 20: c = -16'sd22410;
                21: c = -16'sd17779; 22: c = -16'sd12381; 23: c = -16'sd6372;
                24: c = 16'sd0;      25: c = 16'sd6372;   26: c = 16'sd12381;
                27: c = 16'sd17779;  28: c = 16'sd22410;  29: c = 16'sd26192;
                30: c = 16'sd29097;  31: c = 16'sd31129;  32: c = 16'sd32323;
                33: c = 16'sd32726;  34: c = 16'sd32402;  35: c = 16'sd31419;
                36: c = 16'sd29851;  37: c = 16'sd27775;  38: c = 16'sd25275;
                39: c = 16'sd22435;  40: c = 16'sd19345;  41: c = 16'sd16105;
                42: c = 16'sd12820;  43: c = 16'sd9608;   44: c = 16'sd6602;
                45: c = 16'sd3948;   46: c = 16'sd1814;   47: c = 16'sd385;
                48: c = -16'sd129;
                default: c = 16'sd0;
            endcase
            return c;
        end
    endfunction

endpackage

/* hdl/ppg_beat_detector_unit.sv */
// Top level of the PPG beat detector: filter, mean, sequencer, beat/period logic.
// Depends on pbd_pkg and pbd_corr_row.
//
//   channel  | handshake             | payload
//   in       | in_valid / in_ready   | timestamp, ppg_sample
//   out      | out_valid / out_ready | hpf_value .. accepted_count
//   cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A new sample is taken only once the last result has gone out; the correlation walks the
// cell row through one multiplier, one tap a cycle. Reset clears all state and loads the
// register defaults. A result held by out_ready stalls the next sample.
module ppg_beat_detector_unit
    import pbd_pkg::*;
#(
    parameter int Taps    = TapsDefault,
    parameter int MeanLen = MeanLenDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         timestamp,
    input  logic signed [17:0]  ppg_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  hpf_value,
    output logic signed [31:0]  mean_value,
    output logic                mean_valid,
    output logic signed [47:0]  corr_value,
    output logic                corr_valid,
    output logic                peak_flag,
    output logic                beat_accepted,
    output logic [31:0]         accepted_time,
    output logic [9:0]          accepted_period,
    output logic [15:0]         checked_count,
    output logic [15:0]         accepted_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int FW = $clog2(Taps + 1);
    localparam int MW = $clog2(MeanLen + 1);
    localparam int SW = 32 + $clog2(MeanLen);
    localparam int CW = $clog2(Taps + 4);

    // Mean divide: |sum| * ceil(2^RK / MeanLen) >> RK, exact for any |sum| below 2^SW
    localparam int DL  = $clog2(MeanLen);
    localparam int RW  = SW + 1;
    localparam int RK  = SW + DL;
    localparam int HW  = (SW + 1) / 2;
    localparam int PLW = HW + RW;
    localparam int PHW = SW - HW + RW;
    localparam int QW  = SW + RW;
    localparam logic [RW-1:0] RecipM =
        RW'(((64'd1 << RK) + 64'(MeanLen) - 64'd1) / 64'(MeanLen));

    logic [3:0] shift_reg;
    logic [9:0] minp_reg, maxp_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 4'd5;
            minp_reg  <= 10'd45;
            maxp_reg  <= 10'd200;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                RegHpfShift:  shift_reg <= cfg_data[3:0];
                RegMinPeriod: minp_reg  <= cfg_data[9:0];
                RegMaxPeriod: maxp_reg  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    pbd_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   ts_reg;

    // High-pass, computed on acceptance
    logic signed [17:0] x1_reg;
    logic signed [31:0] y1_reg;
    logic signed [35:0] y_wide;
    logic signed [31:0] y_sat;
    always_comb
    begin
        y_wide = (36'(ppg_sample) <<< 8) - (36'(x1_reg) <<< 8) + 36'(y1_reg)
                 - 36'(y1_reg >>> shift_reg);
        if (y_wide > 36'sd2147483647)
            y_sat = 32'sh7FFFFFFF;
        else if (y_wide < -36'sd2147483648)
            y_sat = 32'sh80000000;
        else
            y_sat = y_wide[31:0];
    end

    logic signed [31:0] mline_reg [MeanLen];
    logic [MW-1:0]      mfill_reg;
    logic signed [SW-1:0] msum;
    logic signed [31:0] mean_reg;
    logic               mvalid_reg;
    logic [FW-1:0]      cfill_reg;

    always_comb
    begin
        msum = '0;
        for (int k = 0; k < MeanLen; k++)
            msum = msum + SW'(mline_reg[k]);
    end

    // Magnitude and the two half products of the reciprocal multiply
    logic [SW-1:0]  mmag_reg;
    logic           mneg_reg;
    logic [PLW-1:0] plo_reg;
    logic [PHW-1:0] phi_reg;
    logic [QW-1:0]  qsum;
    logic [32:0]    qv;

    always_comb
    begin
        qsum = (QW'(phi_reg) << HW) + QW'(plo_reg);
        qv   = 33'(qsum >> RK);
    end

    pbd_row_ctl_t row_ctl;
    logic         acc_clr;
    logic signed [47:0] corr;
    logic         corr_ok;
    logic         accept;

    assign accept = in_valid && in_ready;

    pbd_corr_row #(.Taps(Taps)) u_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (row_ctl),
        .acc_clr (acc_clr),
        .mean_in (mean_reg),
        .mean_ok (mvalid_reg),
        .fill    (cfill_reg),
        .corr    (corr),
        .corr_ok (corr_ok)
    );

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        row_ctl.load   = 1'b0;
        row_ctl.rotate = 1'b0;
        row_ctl.push   = 1'b0;
        acc_clr        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    row_ctl.load = 1'b1;
                    acc_clr      = 1'b1;
                    state_next   = ST_MAC;
                end
            end
            ST_MAC:
            begin
                row_ctl.rotate = 1'b1;
                if (cnt_reg == CW'(Taps + 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                row_ctl.push = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Beat and period state
    logic signed [47:0] pcorr_reg;
    logic pcv_reg, prise_reg, seen_reg;
    logic [9:0] since_reg;
    logic [9:0] ph_reg [3];
    logic       pok_reg [3];
    logic [1:0] hcnt_reg;
    logic [31:0] bt0_reg;
    logic [15:0] chk_reg, pass_reg;

    logic rising, beat, ok_chk;
    logic [9:0] since_inc;
    logic [12:0] p0x, p1x, p2x;
    always_comb
    begin
        rising    = corr_ok && pcv_reg && (corr >= pcorr_reg);
        beat      = prise_reg && !rising && corr_ok && (corr > 48'sd0);
        since_inc = (since_reg == 10'd1023) ? since_reg : since_reg + 10'd1;
        p0x = 13'(since_inc);
        p1x = 13'(ph_reg[0]);
        p2x = 13'(ph_reg[1]);
        ok_chk = seen_reg && pok_reg[0] && pok_reg[1]
                 && (p1x * 13'd5 > p2x * 13'd4) && (p1x * 13'd5 < p2x * 13'd6)
                 && (p1x * 13'd5 > p0x * 13'd4) && (p1x * 13'd5 < p0x * 13'd6)
                 && (ph_reg[0] >= minp_reg) && (ph_reg[0] <= maxp_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ts_reg     <= '0;
            x1_reg     <= '0;
            y1_reg     <= '0;
            mfill_reg  <= '0;
            mean_reg   <= '0;
            mvalid_reg <= 1'b0;
            mmag_reg   <= '0;
            mneg_reg   <= 1'b0;
            plo_reg    <= '0;
            phi_reg    <= '0;
            cfill_reg  <= '0;
            pcorr_reg  <= '0;
            pcv_reg    <= 1'b0;
            prise_reg  <= 1'b0;
            seen_reg   <= 1'b0;
            since_reg  <= '0;
            hcnt_reg   <= '0;
            bt0_reg    <= '0;
            chk_reg    <= '0;
            pass_reg   <= '0;
            peak_flag  <= 1'b0;
            beat_accepted   <= 1'b0;
            accepted_time   <= '0;
            accepted_period <= '0;
            for (int k = 0; k < MeanLen; k++)
                mline_reg[k] <= '0;
            for (int k = 0; k < 3; k++)
            begin
                ph_reg[k]  <= '0;
                pok_reg[k] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == ST_MAC) ? cnt_reg + 1'b1 : '0;
            if (accept)
            begin
                ts_reg    <= timestamp;
                x1_reg    <= ppg_sample;
                y1_reg    <= y_sat;
                mline_reg[0] <= y_sat;
                for (int k = 1; k < MeanLen; k++)
                    mline_reg[k] <= mline_reg[k - 1];
                if (mfill_reg != MW'(MeanLen))
                    mfill_reg <= mfill_reg + 1'b1;
            end
            // Mean in steps: magnitude, then half products, then sum and sign
            if (state_reg == ST_MAC && cnt_reg == '0)
            begin
                mvalid_reg <= (mfill_reg == MW'(MeanLen));
                mneg_reg   <= msum[SW-1];
                mmag_reg   <= msum[SW-1] ? SW'(-msum) : SW'(msum);
            end
            if (state_reg == ST_MAC && cnt_reg == CW'(1))
            begin
                plo_reg <= PLW'(mmag_reg[HW-1:0]) * PLW'(RecipM);
                phi_reg <= PHW'(mmag_reg[SW-1:HW]) * PHW'(RecipM);
            end
            if (state_reg == ST_MAC && cnt_reg == CW'(2))
            begin
                mean_reg <= mvalid_reg ? (mneg_reg ? 32'(-qv) : 32'(qv)) : 32'sd0;
            end
            if (state_reg == ST_FINISH)
            begin
                if (cfill_reg != FW'(Taps))
                    cfill_reg <= cfill_reg + 1'b1;
                prise_reg <= rising;
                pcorr_reg <= corr;
                pcv_reg   <= corr_ok;
                peak_flag <= beat;
                beat_accepted   <= 1'b0;
                accepted_time   <= '0;
                accepted_period <= '0;
                since_reg <= since_inc;
                if (beat)
                begin
                    ph_reg[2]  <= ph_reg[1];  pok_reg[2] <= pok_reg[1];
                    ph_reg[1]  <= ph_reg[0];  pok_reg[1] <= pok_reg[0];
                    ph_reg[0]  <= since_inc;  pok_reg[0] <= seen_reg;
                    since_reg  <= '0;
                    seen_reg   <= 1'b1;
                    bt0_reg    <= ts_reg;
                    if (hcnt_reg != 2'd3)
                        hcnt_reg <= hcnt_reg + 2'd1;
                    if (hcnt_reg >= 2'd2)
                    begin
                        if (chk_reg != 16'hFFFF)
                            chk_reg <= chk_reg + 16'd1;
                        if (ok_chk)
                        begin
                            if (pass_reg != 16'hFFFF)
                                pass_reg <= pass_reg + 16'd1;
                            beat_accepted   <= 1'b1;
                            accepted_time   <= bt0_reg;
                            accepted_period <= ph_reg[0];
                        end
                    end
                end
            end
        end
    end

    // Output holds the finished sample while ST_OUT waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpf_value  <= '0;
            mean_value <= '0;
            mean_valid <= 1'b0;
            corr_value <= '0;
            corr_valid <= 1'b0;
        end
        else if (state_reg == ST_FINISH)
        begin
            hpf_value  <= y1_reg;
            mean_value <= mean_reg;
            mean_valid <= mvalid_reg;
            corr_value <= corr;
            corr_valid <= corr_ok;
        end
    end

    assign out_valid      = (state_reg == ST_OUT);
    assign checked_count  = chk_reg;
    assign accepted_count = pass_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result without finish");
    a_pass_le_chk: assert property (@(posedge clk) disable iff (!rst_n)
        pass_reg <= chk_reg)
        else $error("accepted count above checked count");
    a_acc_needs_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && beat_accepted |-> peak_flag)
        else $error("acceptance without beat");
`endif

endmodule

/* hdl/pbd_cell.sv */
// One cell of the correlation line: holds a mean, its valid bit and a circulating copy with its coefficient.
// Depends on pbd_pkg.
module pbd_cell
    import pbd_pkg::*;
#(
    parameter int Idx  = 0,
    parameter int Taps = TapsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pbd_row_ctl_t        ctl,
    input  logic signed [31:0]  mean_in,
    input  logic                ok_in,
    input  logic signed [31:0]  rot_in,
    input  logic                rot_ok_in,
    input  logic signed [15:0]  coef_in,
    input  logic                cok_in,
    output logic signed [31:0]  mean_out,
    output logic                ok_out,
    output logic signed [31:0]  rot_out,
    output logic                rot_ok_out,
    output logic signed [15:0]  coef_out,
    output logic                cok_out
);

    // Stored line entry (position Idx of the model's line)
    logic signed [31:0] val_reg;
    logic               ok_reg;
    // Circulating copy used while the products are summed
    logic signed [31:0] rot_reg;
    logic               rot_ok_reg;
    logic signed [15:0] coef_reg;
    logic               cok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg    <= '0;
            ok_reg     <= 1'b0;
            rot_reg    <= '0;
            rot_ok_reg <= 1'b0;
            coef_reg   <= '0;
            cok_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.push)
            begin
                val_reg <= mean_in;
                ok_reg  <= ok_in;
            end
            if (ctl.load)
            begin
                rot_reg    <= val_reg;
                rot_ok_reg <= ok_reg;
                coef_reg   <= tpl_coef(Taps - 1 - Idx);
                cok_reg    <= 1'b1;
            end
            else if (ctl.rotate)
            begin
                rot_reg    <= rot_in;
                rot_ok_reg <= rot_ok_in;
                coef_reg   <= coef_in;
                cok_reg    <= cok_in;
            end
        end
    end

    assign mean_out   = val_reg;
    assign ok_out     = ok_reg;
    assign rot_out    = rot_reg;
    assign rot_ok_out = rot_ok_reg;
    assign coef_out   = coef_reg;
    assign cok_out    = cok_reg;

endmodule

/* hdl/pbd_corr_row.sv */
// Row of correlation cells plus the single multiply-accumulate at its tail.
// Depends on pbd_pkg and pbd_cell.
module pbd_corr_row
    import pbd_pkg::*;
#(
    parameter int Taps = TapsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pbd_row_ctl_t        ctl,
    input  logic                acc_clr,
    input  logic signed [31:0]  mean_in,
    input  logic                mean_ok,
    input  logic [$clog2(Taps+1)-1:0] fill,
    output logic signed [47:0]  corr,
    output logic                corr_ok
);

    localparam int FW = $clog2(Taps + 1);

    logic signed [31:0] val   [Taps];
    logic               ok    [Taps];
    logic signed [31:0] rot   [Taps];
    logic               rok   [Taps];
    logic signed [15:0] coef  [Taps];
    logic               cok   [Taps];

    genvar g;
    generate
        for (g = 0; g < Taps; g++)
        begin : g_cell
            pbd_cell #(.Idx(g), .Taps(Taps)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .mean_in    ((g == 0) ? mean_in : val[(g == 0) ? 0 : g - 1]),
                .ok_in      ((g == 0) ? mean_ok : ok[(g == 0) ? 0 : g - 1]),
                .rot_in     ((g == Taps - 1) ? 32'sd0 : rot[(g == Taps - 1) ? g : g + 1]),
                .rot_ok_in  ((g == Taps - 1) ? 1'b0 : rok[(g == Taps - 1) ? g : g + 1]),
                .coef_in    ((g == Taps - 1) ? 16'sd0 : coef[(g == Taps - 1) ? g : g + 1]),
                .cok_in     ((g == Taps - 1) ? 1'b0 : cok[(g == Taps - 1) ? g : g + 1]),
                .mean_out   (val[g]),
                .ok_out     (ok[g]),
                .rot_out    (rot[g]),
                .rot_ok_out (rok[g]),
                .coef_out   (coef[g]),
                .cok_out    (cok[g])
            );
        end
    endgenerate

    // Cell 0 is read each cycle while the row shifts toward it; its position counts up.
    logic [FW-1:0]      pos_reg;
    logic signed [47:0] prod_reg;
    logic               prod_en_reg;
    logic signed [63:0] acc_reg;
    logic               bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            prod_reg    <= '0;
            prod_en_reg <= 1'b0;
            acc_reg     <= '0;
            bad_reg     <= 1'b0;
        end
        else if (acc_clr)
        begin
            pos_reg     <= '0;
            prod_en_reg <= 1'b0;
            acc_reg     <= '0;
            bad_reg     <= 1'b0;
        end
        else
        begin
            prod_en_reg <= 1'b0;
            if (ctl.rotate && cok[0])
            begin
                pos_reg <= pos_reg + 1'b1;
                if (pos_reg < fill)
                begin
                    prod_reg    <= 48'(rot[0] * coef[0]);
                    prod_en_reg <= 1'b1;
                    if (!rok[0])
                        bad_reg <= 1'b1;
                end
            end
            if (prod_en_reg)
                acc_reg <= acc_reg + 64'(prod_reg);
        end
    end

    localparam logic signed [63:0] Hi48 = 64'sd140737488355327;
    localparam logic signed [63:0] Lo48 = -64'sd140737488355328;

    always_comb
    begin
        corr_ok = !bad_reg;
        if (bad_reg)
            corr = '0;
        else if (acc_reg > Hi48)
            corr = Hi48[47:0];
        else if (acc_reg < Lo48)
            corr = Lo48[47:0];
        else
            corr = acc_reg[47:0];
    end

endmodule

/* bench/ppg_beat_detector_unit_tb.sv */
// Self-checking testbench for the PPG beat detector top level.
// Needs pbd_pkg and the detector RTL; carries its own bit-accurate behavioral predictor.
module ppg_beat_detector_unit_tb
    import pbd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAPS = 49;
    localparam int NMEAN = 5;

    typedef struct {
        logic signed [31:0] hpf;
        logic signed [31:0] mean;
        logic               mvalid;
        logic signed [47:0] corr;
        logic               cvalid;
        logic               peak;
        logic               acc;
        logic [31:0]        acc_time;
        logic [9:0]         acc_period;
        logic [15:0]        n_checked;
        logic [15:0]        n_accepted;
    } beat_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [31:0] timestamp = '0;
    logic signed [17:0] ppg_sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] hpf_value, mean_value;
    logic mean_valid, corr_valid, peak_flag, beat_accepted;
    logic signed [47:0] corr_value;
    logic [31:0] accepted_time;
    logic [9:0] accepted_period;
    logic [15:0] checked_count, accepted_count;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    ppg_beat_detector_unit DUT (.*);

    always #5 clk = ~clk;

    // predictor state
    int unsigned    shift_r, minp_r, maxp_r;
    longint         hp_in, hp_out;
    longint         mline[NMEAN];
    int             mfill;
    longint         cline[NTAPS];
    bit             cok[NTAPS];
    int             cfill;
    longint         last_corr;
    bit             last_cvalid, last_rising;
    int unsigned    since_beat;
    bit             beat_seen;
    int unsigned    periods[3];
    bit             period_ok[3];
    int             hist_n;
    logic [31:0]    beat_times[2];
    int unsigned    n_checked, n_accepted;

    beat_result_t   expected_q[$];
    int             errors = 0;
    int             results_seen = 0;
    int             burst_left = 0;

    function automatic longint clamp(longint v, int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint coef(int n);
        return (n >= 0 && n < TplLen) ? longint'(tpl_coef(n)) : 0;
    endfunction

    task automatic reset_predictor();
        shift_r = 5; minp_r = 45; maxp_r = 200;
        hp_in = 0; hp_out = 0; mfill = 0; cfill = 0;
        foreach (mline[k]) mline[k] = 0;
        foreach (cline[k]) begin cline[k] = 0; cok[k] = 0; end
        last_corr = 0; last_cvalid = 0; last_rising = 0;
        since_beat = 0; beat_seen = 0; hist_n = 0;
        foreach (periods[k]) begin periods[k] = 0; period_ok[k] = 0; end
        beat_times[0] = 0; beat_times[1] = 0;
        n_checked = 0; n_accepted = 0;
    endtask

    function automatic beat_result_t predict_beat(logic [31:0] ts, logic signed [17:0] raw);
        beat_result_t r;
        longint y, sum, mean, corr;
        bit mv, cv, rising, beat, ok;
        int unsigned p0, p1, p2;
        y = longint'(raw) * 256 - hp_in * 256 + hp_out - (hp_out >>> shift_r);
        y = clamp(y, 32);
        hp_in = raw;
        hp_out = y;
        for (int k = NMEAN - 1; k > 0; k--) mline[k] = mline[k - 1];
        mline[0] = y;
        if (mfill < NMEAN) mfill++;
        mv = (mfill == NMEAN);
        sum = 0;
        for (int k = 0; k < NMEAN; k++) sum += mline[k];
        mean = mv ? sum / NMEAN : 0;
        sum = 0;
        cv = 1;
        for (int k = 0; k < cfill; k++) begin
            if (!cok[k]) cv = 0;
            sum += coef(NTAPS - 1 - k) * cline[k];
        end
        corr = cv ? clamp(sum, 48) : 0;
        for (int k = NTAPS - 1; k > 0; k--) begin
            cline[k] = cline[k - 1];
            cok[k] = cok[k - 1];
        end
        cline[0] = mean;
        cok[0] = mv;
        if (cfill < NTAPS) cfill++;
        rising = cv && last_cvalid && corr >= last_corr;
        beat = last_rising && !rising && cv && corr > 0;
        last_rising = rising;
        last_corr = corr;
        last_cvalid = cv;
        if (since_beat < 1023) since_beat++;
        r.acc = 0; r.acc_time = 0; r.acc_period = 0;
        if (beat) begin
            periods[2] = periods[1]; period_ok[2] = period_ok[1];
            periods[1] = periods[0]; period_ok[1] = period_ok[0];
            periods[0] = since_beat; period_ok[0] = beat_seen;
            if (hist_n < 3) hist_n++;
            since_beat = 0;
            beat_seen = 1;
            if (hist_n == 3) begin
                p0 = periods[0]; p1 = periods[1]; p2 = periods[2];
                ok = period_ok[0] && period_ok[1] && period_ok[2]
                    && 5 * p1 > 4 * p2 && 5 * p1 < 6 * p2
                    && 5 * p1 > 4 * p0 && 5 * p1 < 6 * p0
                    && p1 >= minp_r && p1 <= maxp_r;
                if (n_checked < 16'hFFFF) n_checked++;
                if (ok) begin
                    if (n_accepted < 16'hFFFF) n_accepted++;
                    r.acc = 1;
                    r.acc_time = beat_times[0];
                    r.acc_period = p1[9:0];
                end
            end
            beat_times[1] = beat_times[0];
            beat_times[0] = ts;
        end
        r.hpf = y[31:0];
        r.mean = mean[31:0];
        r.mvalid = mv;
        r.corr = corr[47:0];
        r.cvalid = cv;
        r.peak = beat;
        r.n_checked = n_checked[15:0];
        r.n_accepted = n_accepted[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    endtask

    // result checker; receiver stalls on its own pattern
    initial begin
        beat_result_t e;
        int mode;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    e = expected_q[0];
                    expected_q.delete(0);
                    if (hpf_value !== e.hpf) report_mismatch("hpf_value", hpf_value, e.hpf);
                    if (mean_value !== e.mean) report_mismatch("mean_value", mean_value, e.mean);
                    if (mean_valid !== e.mvalid)
                        report_mismatch("mean_valid", mean_valid, e.mvalid);
                    if (corr_value !== e.corr) report_mismatch("corr_value", corr_value, e.corr);
                    if (corr_valid !== e.cvalid)
                        report_mismatch("corr_valid", corr_valid, e.cvalid);
                    if (peak_flag !== e.peak) report_mismatch("peak_flag", peak_flag, e.peak);
                    if (beat_accepted !== e.acc)
                        report_mismatch("beat_accepted", beat_accepted, e.acc);
                    if (accepted_time !== e.acc_time)
                        report_mismatch("accepted_time", accepted_time, e.acc_time);
                    if (accepted_period !== e.acc_period)
                        report_mismatch("accepted_period", accepted_period, e.acc_period);
                    if (checked_count !== e.n_checked)
                        report_mismatch("checked_count", checked_count, e.n_checked);
                    if (accepted_count !== e.n_accepted)
                        report_mismatch("accepted_count", accepted_count, e.n_accepted);
                end
                results_seen++;
            end
            mode = (results_seen / 150) % 3;
            if (!rst_n) out_ready <= 1'b0;
            else if (mode == 0) out_ready <= 1'b1;
            else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
            else out_ready <= ($urandom_range(0, 99) < 30);
        end
    end

    // one sample request, with bursty gaps before it; valid stays up inside a burst
    task automatic send_sample(logic [31:0] ts, logic signed [17:0] raw);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 80)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        timestamp <= ts;
        ppg_sample <= raw;
        do @(posedge clk); while (!in_ready);
        expected_q.insert(expected_q.size(), predict_beat(ts, raw));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == RegHpfShift) shift_r = val[3:0];
        else if (idx == RegMinPeriod) minp_r = val[9:0];
        else if (idx == RegMaxPeriod) maxp_r = val[9:0];
    endtask

    logic [31:0] ts_now = 0;

    // periodic pulse train with jitter so beats and period checks happen
    task automatic send_pulses(int n, int period, int amp, int jitter, int noise);
        int ph, per;
        int v;
        ph = 0;
        per = period;
        for (int i = 0; i < n; i++) begin
            v = (ph < per / 4) ? amp : -amp / 3;
            v += $urandom_range(0, 2 * noise) - noise;
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            ts_now += $urandom_range(0, 3);
            send_sample(ts_now, 18'(v));
            ph++;
            if (ph >= per) begin
                ph = 0;
                per = period + $urandom_range(0, 2 * jitter) - jitter;
                if (per < 4) per = 4;
            end
        end
    endtask

    task automatic test_extremes();
        send_sample(32'hFFFF_FFFF, 18'sh1FFFF);
        send_sample(32'h0, -18'sd131072);
        send_sample(32'hAAAA_5555, 18'sh1FFFF);
        send_sample(32'h5555_AAAA, -18'sd131072);
        send_sample(32'h0, 18'sd0);
        for (int i = 0; i < 8; i++) begin
            send_sample(ts_now, (i % 2) ? -18'sd131072 : 18'sh1FFFF);
            ts_now++;
        end
        drain();
    endtask

    task automatic test_shift_extremes();
        write_reg(RegHpfShift, 0);
        for (int i = 0; i < 6; i++) begin
            send_sample(ts_now, 18'sh1FFFF);
            ts_now++;
        end
        drain();
        write_reg(RegHpfShift, 15);
        for (int i = 0; i < 6; i++) begin
            send_sample(ts_now, -18'sd131072);
            ts_now++;
        end
        drain();
        write_reg(RegHpfShift, 5);
    endtask

    task automatic test_beats_default();
        send_pulses(350, 80, 60000, 3, 500);
        drain();
    endtask

    task automatic test_bounds();
        write_reg(RegMinPeriod, 1);
        write_reg(RegMaxPeriod, 1023);
        write_reg(RegHpfShift, 3);
        send_pulses(250, 60, 90000, 4, 2000);
        drain();
        write_reg(RegMinPeriod, 1023);   // crossed bounds
        write_reg(RegMaxPeriod, 1);
        send_pulses(200, 50, 80000, 2, 1000);
        // hold off until everything is back
        drain();
        write_reg(RegMinPeriod, 30);
        write_reg(RegMaxPeriod, 90);
        write_reg(RegHpfShift, 7);
        send_pulses(250, 70, 120000, 8, 3000);
        drain();
    endtask

    task automatic test_random_mix();
        int v;
        write_reg(RegHpfShift, $urandom_range(1, 15));
        write_reg(RegMinPeriod, $urandom_range(10, 60));
        write_reg(RegMaxPeriod, $urandom_range(60, 400));
        send_pulses(200, $urandom_range(20, 120), $urandom_range(1000, 131071), 5, 4000);
        for (int i = 0; i < 120; i++) begin
            v = $urandom_range(0, 262143);
            send_sample($urandom, 18'(v));
        end
        drain();
    endtask

    initial begin
        reset_predictor();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_shift_extremes();
        test_beats_default();
        test_bounds();
        test_random_mix();
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #30ms;
        $display("status: fail");
        $finish;
    end
endmodule
